### rtl/vertex_rotate_project_defines.svh
// ----------------------------------------------------------------------------
// vertex_rotate_project_defines
// assertion macros used by the port-level checker of the vertex transform
// ----------------------------------------------------------------------------
`ifndef VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while in reset
`define VRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while in reset
`define VRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/vrp_pkg.sv
// ----------------------------------------------------------------------------
// vrp_pkg
// constants and register codes of the vertex rotate and project pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vrp_pkg;

  localparam int CoordBits  = 16;
  localparam int FracBits   = 14;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 32;

  // cos(30 deg) with 30 fraction bits, rounded to nearest at the working precision later
  localparam longint IsoCosQ30 = 64'sd929887697;

  // cos 1.0 in the high half, sin 0 in the low half
  localparam logic [31:0] TrigReset = 32'h4000_0000;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgZoom       = 3'd0,
    CfgZZoom      = 3'd1,
    CfgTrigX      = 3'd2,
    CfgTrigY      = 3'd3,
    CfgTrigZ      = 3'd4,
    CfgIsoMode    = 3'd5,
    CfgPreOffset  = 3'd6,
    CfgPostOffset = 3'd7
  } cfg_idx_e;

endpackage

`default_nettype wire

### rtl/vertex_rotate_project.sv
// ----------------------------------------------------------------------------
// vertex_rotate_project
// Map point to screen position: each input word (x, y, z) is scaled by zoom
// and z zoom, shifted by the centering offsets, rotated about the x, y and z
// axes with software-supplied cos/sin pairs (signed, FRAC_BITS fraction bits,
// truncated toward zero after every rotation), optionally folded through the
// fixed 30-degree isometric map, shifted by the screen offsets and saturated
// to COORD_BITS signed bits. The datapath is a nine-stage pipeline: one scale
// stage, then for each rotation a multiply stage and a sum/truncate stage,
// then an isometric multiply stage and a final offset/saturate stage. A new
// word is taken every cycle unless the pipeline is full and the output side
// stalls. Stalls back up only as far as the first empty stage, so bubbles
// are squeezed out and input keeps flowing while a result waits.
// Configuration writes are always ready and must only be issued while the
// pipeline is empty; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vertex_rotate_project #(
  parameter int COORD_BITS = vrp_pkg::CoordBits,
  parameter int FRAC_BITS  = vrp_pkg::FracBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vrp_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [vrp_pkg::CfgDataBits-1:0]     cfg_data_i,
  // point input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [COORD_BITS-1:0]        x_in_i,
  input  logic signed [COORD_BITS-1:0]        y_in_i,
  input  logic signed [COORD_BITS-1:0]        z_in_i,
  // screen position output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [COORD_BITS-1:0]        x_out_o,
  output logic signed [COORD_BITS-1:0]        y_out_o,
  output logic signed [COORD_BITS-1:0]        z_out_o
);

  import vrp_pkg::*;

  // datapath widths
  localparam int SW = COORD_BITS + 9;                     // coord times 8-bit zoom
  localparam int W0 = SW + 1;                             // after centering offset
  localparam int Gr = (17 > FRAC_BITS) ? 17 - FRAC_BITS : 0; // growth per rotation
  localparam int R1 = W0 + Gr;                            // after x-axis rotation
  localparam int R2 = R1 + Gr;                            // after y-axis rotation
  localparam int R3 = R2 + Gr;                            // after z-axis rotation
  localparam int HW = R3 + 1;                             // iso sum / difference
  localparam int YW = R3 + 2;                             // iso y before offset
  localparam int XW = R3 + 3;                             // selected x / y
  localparam int FW = R3 + 4;                             // after screen offset
  localparam int PW = R3 + FRAC_BITS + 3;                 // widest working value
  localparam int NumStages = 9;

  // cos(30 deg) at FRAC_BITS fraction bits, rounded to nearest
  localparam longint IsoCos =
    (IsoCosQ30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  localparam logic signed [FRAC_BITS+1:0] IsoCoef = IsoCos[FRAC_BITS+1:0];

  // truncating division by 2^FRAC_BITS, toward zero
  function automatic logic signed [PW-1:0] trunc_frac(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] bias;
    bias = '0;
    bias[FRAC_BITS-1:0] = {FRAC_BITS{v[PW-1]}};
    return (v + bias) >>> FRAC_BITS;
  endfunction

  // clamp to the signed coordinate range
  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [PW-1:0] v
  );
    logic signed [PW-1:0] hi_lim;
    logic signed [PW-1:0] lo_lim;
    hi_lim = '0;
    hi_lim[COORD_BITS-2:0] = '1;
    lo_lim = ~hi_lim;
    if (v > hi_lim) begin
      return hi_lim[COORD_BITS-1:0];
    end else if (v < lo_lim) begin
      return lo_lim[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  zoom_q;
  logic [7:0]  z_zoom_q;
  logic [31:0] trig_x_q;
  logic [31:0] trig_y_q;
  logic [31:0] trig_z_q;
  logic        iso_mode_q;
  logic [31:0] pre_offset_q;
  logic [31:0] post_offset_q;

  // the register file never pushes back
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q        <= 8'd1;
      z_zoom_q      <= 8'd1;
      trig_x_q      <= TrigReset;
      trig_y_q      <= TrigReset;
      trig_z_q      <= TrigReset;
      iso_mode_q    <= 1'b0;
      pre_offset_q  <= '0;
      post_offset_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgZoom:       zoom_q        <= cfg_data_i[7:0];
        CfgZZoom:      z_zoom_q      <= cfg_data_i[7:0];
        CfgTrigX:      trig_x_q      <= cfg_data_i[31:0];
        CfgTrigY:      trig_y_q      <= cfg_data_i[31:0];
        CfgTrigZ:      trig_z_q      <= cfg_data_i[31:0];
        CfgIsoMode:    iso_mode_q    <= cfg_data_i[0];
        CfgPreOffset:  pre_offset_q  <= cfg_data_i[31:0];
        CfgPostOffset: post_offset_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // unpacked register halves
  logic signed [15:0] cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;
  logic signed [15:0] pre_x, pre_y, post_x, post_y;

  assign cos_x  = $signed(trig_x_q[31:16]);
  assign sin_x  = $signed(trig_x_q[15:0]);
  assign cos_y  = $signed(trig_y_q[31:16]);
  assign sin_y  = $signed(trig_y_q[15:0]);
  assign cos_z  = $signed(trig_z_q[31:16]);
  assign sin_z  = $signed(trig_z_q[15:0]);
  assign pre_x  = $signed(pre_offset_q[31:16]);
  assign pre_y  = $signed(pre_offset_q[15:0]);
  assign post_x = $signed(post_offset_q[31:16]);
  assign post_y = $signed(post_offset_q[15:0]);

  // --------------------------------------------------------------------------
  // pipeline control: a stage loads when it is empty or its successor moves
  // --------------------------------------------------------------------------
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: zoom
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] s1_x_d, s1_y_d, s1_z_d;
  logic signed [SW-1:0] s1_x_q, s1_y_q, s1_z_q;

  always_comb begin
    s1_x_d = $signed(x_in_i) * $signed({1'b0, zoom_q});
    s1_y_d = $signed(y_in_i) * $signed({1'b0, zoom_q});
    s1_z_d = $signed(z_in_i) * $signed({1'b0, z_zoom_q});
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_x_q <= s1_x_d;
      s1_y_q <= s1_y_d;
      s1_z_q <= s1_z_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: centering, products of the x-axis rotation (y, z pair)
  // --------------------------------------------------------------------------
  logic signed [W0-1:0]    s2_x0, s2_y0, s2_z0;
  logic signed [W0-1:0]    s2_x_q;
  logic signed [W0+15:0]   s2_yc_d, s2_zs_d, s2_zc_d, s2_ys_d;
  logic signed [W0+15:0]   s2_yc_q, s2_zs_q, s2_zc_q, s2_ys_q;

  always_comb begin
    s2_x0   = W0'(s1_x_q) - W0'(pre_x);
    s2_y0   = W0'(s1_y_q) - W0'(pre_y);
    s2_z0   = W0'(s1_z_q);
    s2_yc_d = s2_y0 * cos_x;
    s2_zs_d = s2_z0 * sin_x;
    s2_zc_d = s2_z0 * cos_x;
    s2_ys_d = s2_y0 * sin_x;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_x_q  <= s2_x0;
      s2_yc_q <= s2_yc_d;
      s2_zs_q <= s2_zs_d;
      s2_zc_q <= s2_zc_d;
      s2_ys_q <= s2_ys_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: sums of the x-axis rotation
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] s3_ty, s3_tz;
  logic signed [R1-1:0] s3_y_d, s3_z_d;
  logic signed [R1-1:0] s3_y_q, s3_z_q;
  logic signed [W0-1:0] s3_x_q;

  always_comb begin
    s3_ty  = trunc_frac(PW'(s2_yc_q) + PW'(s2_zs_q));
    s3_tz  = trunc_frac(PW'(s2_zc_q) - PW'(s2_ys_q));
    s3_y_d = R1'(s3_ty);
    s3_z_d = R1'(s3_tz);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_x_q <= s2_x_q;
      s3_y_q <= s3_y_d;
      s3_z_q <= s3_z_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: products of the y-axis rotation (x, z pair)
  // --------------------------------------------------------------------------
  logic signed [R1-1:0]  s4_xe;
  logic signed [R1+15:0] s4_xc_d, s4_zs_d, s4_zc_d, s4_xs_d;
  logic signed [R1+15:0] s4_xc_q, s4_zs_q, s4_zc_q, s4_xs_q;
  logic signed [R1-1:0]  s4_y_q;

  always_comb begin
    s4_xe   = R1'(s3_x_q);
    s4_xc_d = s4_xe * cos_y;
    s4_zs_d = s3_z_q * sin_y;
    s4_zc_d = s3_z_q * cos_y;
    s4_xs_d = s4_xe * sin_y;
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_y_q  <= s3_y_q;
      s4_xc_q <= s4_xc_d;
      s4_zs_q <= s4_zs_d;
      s4_zc_q <= s4_zc_d;
      s4_xs_q <= s4_xs_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: sums of the y-axis rotation
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] s5_tx, s5_tz;
  logic signed [R2-1:0] s5_x_d, s5_z_d;
  logic signed [R2-1:0] s5_x_q, s5_z_q;
  logic signed [R1-1:0] s5_y_q;

  always_comb begin
    s5_tx  = trunc_frac(PW'(s4_xc_q) + PW'(s4_zs_q));
    s5_tz  = trunc_frac(PW'(s4_zc_q) - PW'(s4_xs_q));
    s5_x_d = R2'(s5_tx);
    s5_z_d = R2'(s5_tz);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_x_q <= s5_x_d;
      s5_y_q <= s4_y_q;
      s5_z_q <= s5_z_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: products of the z-axis rotation (x, y pair, minus on x)
  // --------------------------------------------------------------------------
  logic signed [R2-1:0]  s6_ye;
  logic signed [R2+15:0] s6_xc_d, s6_ys_d, s6_xs_d, s6_yc_d;
  logic signed [R2+15:0] s6_xc_q, s6_ys_q, s6_xs_q, s6_yc_q;
  logic signed [R2-1:0]  s6_z_q;

  always_comb begin
    s6_ye   = R2'(s5_y_q);
    s6_xc_d = s5_x_q * cos_z;
    s6_ys_d = s6_ye * sin_z;
    s6_xs_d = s5_x_q * sin_z;
    s6_yc_d = s6_ye * cos_z;
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_z_q  <= s5_z_q;
      s6_xc_q <= s6_xc_d;
      s6_ys_q <= s6_ys_d;
      s6_xs_q <= s6_xs_d;
      s6_yc_q <= s6_yc_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: sums of the z-axis rotation
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] s7_tx, s7_ty;
  logic signed [R3-1:0] s7_x_d, s7_y_d;
  logic signed [R3-1:0] s7_x_q, s7_y_q;
  logic signed [R2-1:0] s7_z_q;

  always_comb begin
    s7_tx  = trunc_frac(PW'(s6_xc_q) - PW'(s6_ys_q));
    s7_ty  = trunc_frac(PW'(s6_xs_q) + PW'(s6_yc_q));
    s7_x_d = R3'(s7_tx);
    s7_y_d = R3'(s7_ty);
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_x_q <= s7_x_d;
      s7_y_q <= s7_y_d;
      s7_z_q <= s6_z_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 8: isometric terms, x - y by cos(30 deg), y as half the sum minus z
  // --------------------------------------------------------------------------
  logic signed [HW-1:0] s8_diff, s8_sum, s8_half;
  logic signed [PW-1:0] s8_pd_d, s8_pd_q;
  logic signed [YW-1:0] s8_hy_d, s8_hy_q;
  logic signed [R3-1:0] s8_x_q, s8_y_q;
  logic signed [R2-1:0] s8_z_q;

  always_comb begin
    s8_diff = HW'(s7_x_q) - HW'(s7_y_q);
    s8_sum  = HW'(s7_x_q) + HW'(s7_y_q);
    // halving rounds toward zero
    s8_half = (s8_sum + $signed({{R3{1'b0}}, s8_sum[HW-1]})) >>> 1;
    s8_pd_d = s8_diff * IsoCoef;
    s8_hy_d = YW'(s8_half) - YW'(s7_z_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s8_pd_q <= s8_pd_d;
      s8_hy_q <= s8_hy_d;
      s8_x_q  <= s7_x_q;
      s8_y_q  <= s7_y_q;
      s8_z_q  <= s7_z_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 9: mode select, screen offsets, saturation into the output word
  // --------------------------------------------------------------------------
  logic signed [PW-1:0]         s9_xi;
  logic signed [XW-1:0]         s9_x_sel, s9_y_sel;
  logic signed [FW-1:0]         s9_fx, s9_fy;
  logic signed [COORD_BITS-1:0] x_out_d, y_out_d, z_out_d;
  logic signed [COORD_BITS-1:0] x_out_q, y_out_q, z_out_q;

  always_comb begin
    s9_xi = trunc_frac(s8_pd_q);
    if (iso_mode_q) begin
      s9_x_sel = XW'(s9_xi);
      s9_y_sel = XW'(s8_hy_q);
    end else begin
      s9_x_sel = XW'(s8_x_q);
      s9_y_sel = XW'(s8_y_q);
    end
    s9_fx   = FW'(s9_x_sel) + FW'(post_x);
    s9_fy   = FW'(s9_y_sel) + FW'(post_y);
    x_out_d = sat_coord(PW'(s9_fx));
    y_out_d = sat_coord(PW'(s9_fy));
    z_out_d = sat_coord(PW'(s8_z_q));
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      x_out_q <= x_out_d;
      y_out_q <= y_out_d;
      z_out_q <= z_out_d;
    end
  end

  assign x_out_o = x_out_q;
  assign y_out_o = y_out_q;
  assign z_out_o = z_out_q;

endmodule

`default_nettype wire

### rtl/vrp_checker.sv
// ----------------------------------------------------------------------------
// vrp_checker
// port-level checks of the vertex transform, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "vertex_rotate_project_defines.svh"

module vrp_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [COORD_BITS-1:0] x_out_o,
  input logic signed [COORD_BITS-1:0] y_out_o,
  input logic signed [COORD_BITS-1:0] z_out_o
);

  // a held result word stays put
  `VRP_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(x_out_o) && $stable(y_out_o) && $stable(z_out_o), "result word changed while stalled")

  // backpressure only ever starts at a blocked output word
  `VRP_ASSERT_IMP(a_stall_origin, in_stall_o, out_valid_o && out_stall_i, "input stalled with no blocked result")

  // register writes are never refused
  `VRP_ASSERT_IMP(a_cfg_open, cfg_valid_i, cfg_ready_o, "config write refused")

endmodule

bind vertex_rotate_project vrp_checker #(.COORD_BITS(COORD_BITS)) u_vrp_checker (.*);

`default_nettype wire

### dv/screen_pos_checker.sv
// ----------------------------------------------------------------------------
// screen_pos_checker
// Watches the register, point and screen-position channels of the vertex
// transform, keeps its own copy of the registers, works out the screen
// position of every accepted point and compares each delivered word with
// the oldest outstanding one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module screen_pos_checker
  import vrp_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [CfgIdxBits-1:0]        cfg_index_i,
  input  logic [CfgDataBits-1:0]       cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic signed [CoordBits-1:0]  x_in_i,
  input  logic signed [CoordBits-1:0]  y_in_i,
  input  logic signed [CoordBits-1:0]  z_in_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic signed [CoordBits-1:0]  x_out_i,
  input  logic signed [CoordBits-1:0]  y_out_i,
  input  logic signed [CoordBits-1:0]  z_out_i,
  output int unsigned                  mismatch_cnt_o,
  output int unsigned                  pending_cnt_o
);

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
  } pair_t;

  localparam longint OneQ   = longint'(1) <<< FracBits;
  localparam longint IsoCos = (IsoCosQ30 + (longint'(1) <<< (29 - FracBits)))
                              >>> (30 - FracBits);
  localparam longint IsoSin = longint'(1) <<< (FracBits - 1);
  localparam longint SatMax = (longint'(1) <<< (CoordBits - 1)) - 1;
  localparam longint SatMin = -SatMax - 1;

  logic [7:0]  zoom_q;
  logic [7:0]  z_zoom_q;
  logic [31:0] trig_x_q;
  logic [31:0] trig_y_q;
  logic [31:0] trig_z_q;
  logic        iso_q;
  logic [31:0] pre_off_q;
  logic [31:0] post_off_q;

  point_t      expected_pos_q[$];
  int unsigned mismatches;

  // one truncating rotation step; cos in the high half, sin in the low half
  function automatic pair_t rotate_pair(longint a, longint b, logic [31:0] cs,
                                        bit minus_on_a);
    longint c;
    longint s;
    pair_t  r;
    c = $signed(cs[31:16]);
    s = $signed(cs[15:0]);
    if (minus_on_a) begin
      r.a = (a * c - b * s) / OneQ;
      r.b = (a * s + b * c) / OneQ;
    end else begin
      r.a = (a * c + b * s) / OneQ;
      r.b = (b * c - a * s) / OneQ;
    end
    return r;
  endfunction

  function automatic logic signed [CoordBits-1:0] clamp(longint v);
    if (v > SatMax) return SatMax[CoordBits-1:0];
    if (v < SatMin) return SatMin[CoordBits-1:0];
    return v[CoordBits-1:0];
  endfunction

  function automatic point_t project_point(point_t p);
    longint x;
    longint y;
    longint z;
    longint zm;
    longint zzm;
    longint off_hi;
    longint off_lo;
    longint ix;
    longint iy;
    pair_t  t;
    point_t r;
    zm  = zoom_q;
    zzm = z_zoom_q;
    x = p.x;
    y = p.y;
    z = p.z;
    x = x * zm;
    y = y * zm;
    z = z * zzm;
    off_hi = $signed(pre_off_q[31:16]);
    off_lo = $signed(pre_off_q[15:0]);
    x = x - off_hi;
    y = y - off_lo;
    t = rotate_pair(y, z, trig_x_q, 1'b0);
    y = t.a;
    z = t.b;
    t = rotate_pair(x, z, trig_y_q, 1'b0);
    x = t.a;
    z = t.b;
    t = rotate_pair(x, y, trig_z_q, 1'b1);
    x = t.a;
    y = t.b;
    if (iso_q) begin
      ix = ((x - y) * IsoCos) / OneQ;
      iy = ((x + y) * IsoSin) / OneQ - z;
      x  = ix;
      y  = iy;
    end
    off_hi = $signed(post_off_q[31:16]);
    off_lo = $signed(post_off_q[15:0]);
    x = x + off_hi;
    y = y + off_lo;
    r.x = clamp(x);
    r.y = clamp(y);
    r.z = clamp(z);
    return r;
  endfunction

  function automatic int unsigned field_mismatch(string name,
                                                  logic signed [CoordBits-1:0] want,
                                                  logic signed [CoordBits-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_t want_pos;
    point_t seen_pt;
    if (!rst_ni) begin
      zoom_q     = 8'd1;
      z_zoom_q   = 8'd1;
      trig_x_q   = TrigReset;
      trig_y_q   = TrigReset;
      trig_z_q   = TrigReset;
      iso_q      = 1'b0;
      pre_off_q  = '0;
      post_off_q = '0;
      mismatches = 0;
      expected_pos_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgZoom:       zoom_q     = cfg_data_i[7:0];
          CfgZZoom:      z_zoom_q   = cfg_data_i[7:0];
          CfgTrigX:      trig_x_q   = cfg_data_i;
          CfgTrigY:      trig_y_q   = cfg_data_i;
          CfgTrigZ:      trig_z_q   = cfg_data_i;
          CfgIsoMode:    iso_q      = cfg_data_i[0];
          CfgPreOffset:  pre_off_q  = cfg_data_i;
          CfgPostOffset: post_off_q = cfg_data_i;
          default: ;
        endcase
      end
      // compare before queuing, so a stray word never meets its own prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_pos_q.size() == 0) begin
          $error("screen word with nothing outstanding: x %0d y %0d z %0d",
                 x_out_i, y_out_i, z_out_i);
          mismatches++;
        end else begin
          want_pos = expected_pos_q.pop_front();
          mismatches += field_mismatch("x_out", want_pos.x, x_out_i);
          mismatches += field_mismatch("y_out", want_pos.y, y_out_i);
          mismatches += field_mismatch("z_out", want_pos.z, z_out_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        seen_pt = {x_in_i, y_in_i, z_in_i};
        expected_pos_q.push_back(project_point(seen_pt));
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_cnt_o  <= expected_pos_q.size();
  end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the vertex rotate/project pipeline. Runs a few
// corner points under the reset registers and under two extreme settings,
// then random points under a series of random register settings, with
// bursty input, a varying output stall pattern and a cycle limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import vrp_pkg::*;

  localparam int          CycleLimit   = 400000;
  localparam int          DrainCycles  = 16;    // nine-stage pipe plus margin
  localparam int          RandPhases   = 8;
  localparam int          PhaseWords   = 106;
  localparam logic signed [CoordBits-1:0] MaxC = 16'sh7FFF;
  localparam logic signed [CoordBits-1:0] MinC = 16'sh8000;

  typedef struct packed {
    logic [7:0]  zoom;
    logic [7:0]  z_zoom;
    logic [31:0] trig_x;
    logic [31:0] trig_y;
    logic [31:0] trig_z;
    logic        iso;
    logic [31:0] pre_off;
    logic [31:0] post_off;
  } setting_t;

  // every block input starts at a known value
  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [CfgIdxBits-1:0]        cfg_index_i = '0;
  logic [CfgDataBits-1:0]       cfg_data_i  = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic signed [CoordBits-1:0]  x_in_i      = '0;
  logic signed [CoordBits-1:0]  y_in_i      = '0;
  logic signed [CoordBits-1:0]  z_in_i      = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [CoordBits-1:0]  x_out_o;
  logic signed [CoordBits-1:0]  y_out_o;
  logic signed [CoordBits-1:0]  z_out_o;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned cycle_cnt  = 0;
  int unsigned burst_left = 0;
  logic [1:0]  stall_mode = 2'd0;
  logic [7:0]  stall_left = 8'd0;

  always #5 clk_i = ~clk_i;

  vertex_rotate_project DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .x_in_i      (x_in_i),
    .y_in_i      (y_in_i),
    .z_in_i      (z_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .x_out_o     (x_out_o),
    .y_out_o     (y_out_o),
    .z_out_o     (z_out_o)
  );

  screen_pos_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .x_in_i         (x_in_i),
    .y_in_i         (y_in_i),
    .z_in_i         (z_in_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .x_out_i        (x_out_o),
    .y_out_i        (y_out_o),
    .z_out_i        (z_out_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  // run limit: only a hung or lost word gets here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // output stall: switches among four patterns, each held for a random span
  //   0 never stalls, 1 light random, 2 heavy random, 3 follows a countdown bit
  always @(posedge clk_i) begin
    if (stall_left == 8'd0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_left <= 8'($urandom_range(32, 200));
    end else begin
      stall_left <= stall_left - 8'd1;
    end
    case (stall_mode)
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= stall_left[3];
    endcase
  end

  // one register write; valid stays up so back-to-back writes need no toggle
  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // writes all eight registers; unused upper bits carry noise
  task automatic load_setting(setting_t s);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(CfgZoom, {junk[31:8], s.zoom});
    junk = $urandom;
    write_reg(CfgZZoom, {junk[31:8], s.z_zoom});
    write_reg(CfgTrigX, s.trig_x);
    write_reg(CfgTrigY, s.trig_y);
    write_reg(CfgTrigZ, s.trig_z);
    junk = $urandom;
    write_reg(CfgIsoMode, {junk[31:1], s.iso});
    write_reg(CfgPreOffset, s.pre_off);
    write_reg(CfgPostOffset, s.post_off);
    cfg_valid_i <= 1'b0;
  endtask

  // sends one point word; bursts of random length separated by random gaps
  task automatic feed_point(logic signed [CoordBits-1:0] px,
                            logic signed [CoordBits-1:0] py,
                            logic signed [CoordBits-1:0] pz);
    int unsigned gap_len;
    if (burst_left == 0) begin
      gap_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap_len > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    x_in_i     <= px;
    y_in_i     <= py;
    z_in_i     <= pz;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // quiet both request channels and wait until every position is back
  task automatic settle();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic corner_points();
    feed_point(0, 0, 0);
    feed_point(MaxC, MaxC, MaxC);
    feed_point(MinC, MinC, MinC);
    feed_point(MaxC, MinC, 0);
    feed_point(MinC, MaxC, -1);
    feed_point(1, -1, MaxC);
    feed_point(-1, 1, MinC);
    feed_point(MaxC, 0, MinC);
  endtask

  // cos/sin pair of a whole-degree angle in the block's fixed-point format
  function automatic logic [31:0] angle_trig();
    real ang;
    int  c;
    int  s;
    ang = real'($urandom_range(0, 359)) * 3.14159265358979 / 180.0;
    c   = $rtoi($cos(ang) * real'(1 << FracBits));
    s   = $rtoi($sin(ang) * real'(1 << FracBits));
    return {c[15:0], s[15:0]};
  endfunction

  function automatic logic [31:0] pick_trig();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return TrigReset;
      default: return angle_trig();
    endcase
  endfunction

  function automatic logic [7:0] pick_scale();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd1;
      3:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [31:0] pick_offsets();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return '0;
      default: return {16'($urandom_range(0, 4000) - 2000),
                       16'($urandom_range(0, 4000) - 2000)};
    endcase
  endfunction

  // mostly small points so rotations show, some full range and corners
  function automatic logic signed [CoordBits-1:0] pick_coord();
    case ($urandom_range(0, 9))
      6, 7:    return 16'($urandom);
      8: begin
        case ($urandom_range(0, 4))
          0:       return MaxC;
          1:       return MinC;
          2:       return 16'sd0;
          3:       return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      9:       return 16'($urandom_range(0, 8000) - 4000);
      default: return 16'($urandom_range(0, 600) - 300);
    endcase
  endfunction

  initial begin
    setting_t s;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners under the reset registers
    corner_points();

    // largest scales, 30/90/180 degree turns, isometric, offsets at the rails
    settle();
    s = '{zoom: 8'd255, z_zoom: 8'd255, trig_x: 32'h376D_2000,
          trig_y: 32'h0000_4000, trig_z: 32'hC000_0000, iso: 1'b1,
          pre_off: 32'h8000_7FFF, post_off: 32'h7FFF_8000};
    load_setting(s);
    corner_points();

    // zero x/y zoom, trig values near +-2.0, no isometric map
    settle();
    s = '{zoom: 8'd0, z_zoom: 8'd255, trig_x: 32'h7FFF_8000,
          trig_y: 32'h8000_7FFF, trig_z: 32'h7FFF_7FFF, iso: 1'b0,
          pre_off: 32'h7FFF_8000, post_off: 32'h8000_7FFF};
    load_setting(s);
    corner_points();

    // random settings, each with a stream of random points
    for (int ph = 0; ph < RandPhases; ph++) begin
      settle();
      s.zoom     = pick_scale();
      s.z_zoom   = pick_scale();
      s.trig_x   = pick_trig();
      s.trig_y   = pick_trig();
      s.trig_z   = pick_trig();
      s.iso      = 1'($urandom_range(0, 1));
      s.pre_off  = pick_offsets();
      s.post_off = pick_offsets();
      load_setting(s);
      repeat (PhaseWords) feed_point(pick_coord(), pick_coord(), pick_coord());
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
